// ===== rtl/core/b64bd_pkg.sv =====
// Shared types, constants and the character map for the base64 blob decoder.
package b64bd_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CODE_PAD = 8'd254;
    localparam logic [7:0] CODE_BAD = 8'd255;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [7:0] offender;
        logic       last;
    } out_word_t;

    // One entry per input character that causes results: one to three words.
    typedef struct packed {
        logic [1:0] count;
        logic [1:0] kind;
        logic [7:0] offender;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } job_t;

    function automatic logic [7:0] map_char(input logic [7:0] ch);
        logic [7:0] code;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            code = ch - 8'h41;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            code = ch - 8'h61 + 8'd26;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            code = ch - 8'h30 + 8'd52;
        end else if (ch == 8'h2B) begin
            code = 8'd62;
        end else if (ch == 8'h2F) begin
            code = 8'd63;
        end else if (ch == 8'h3D) begin
            code = CODE_PAD;
        end else begin
            code = CODE_BAD;
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/base64_blob_decoder.sv =====
// Top level of the base64 blob decoder: front end, job queue and result sequencer.
// A result word passes through the job queue and then the output register.
// Throughput: one character per cycle while full is low; one result word per cycle
// while popped; a four-entry job queue absorbs the three words of a full group.
// Reset: asynchronous, active low; the decoder waits for the opening bracket again.
module base64_blob_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64bd_pkg::in_word_t  item,
    output logic                empty,
    input  logic                pop,
    output b64bd_pkg::out_word_t result
);
    import b64bd_pkg::*;

    logic job_push;
    job_t job;
    job_t head;
    logic fifo_empty;
    logic fifo_full;
    logic fifo_pop;

    assign full = fifo_full;

    b64bd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (push && !fifo_full),
        .item     (item),
        .job_push (job_push),
        .job      (job)
    );

    b64bd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job),
        .pop        (fifo_pop),
        .head       (head),
        .fifo_empty (fifo_empty),
        .fifo_full  (fifo_full)
    );

    b64bd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (fifo_empty),
        .fifo_pop   (fifo_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !fifo_full)
        else $error("job queued while the queue is full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("job retired from an empty queue");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_DATA) |-> (result.last && result.out_byte == 8'd0))
        else $error("close or error word is not a lone final word");

    a_data_no_offender: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_DATA) |-> (result.offender == 8'd0))
        else $error("data word carries an offender");
`endif

endmodule

// ===== rtl/core/b64bd_front.sv =====
// Front end: takes characters, tracks the group state and issues jobs for results.
module b64bd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  b64bd_pkg::in_word_t item,
    output logic               job_push,
    output b64bd_pkg::job_t    job
);
    import b64bd_pkg::*;

    localparam logic [2:0] PH_OPEN   = 3'd0;
    localparam logic [2:0] PH_G1     = 3'd1;
    localparam logic [2:0] PH_G2     = 3'd2;
    localparam logic [2:0] PH_G3     = 3'd3;
    localparam logic [2:0] PH_G4     = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_FAILED = 3'd6;

    localparam logic [7:0] CH_OPEN    = 8'h5B;
    localparam logic [7:0] CH_CLOSE   = 8'h5D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_FEED    = 8'h0C;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    logic [2:0] phase_reg, phase_next;
    logic       comment_reg, comment_next;
    logic [5:0] first_reg, first_next;
    logic [5:0] second_reg, second_next;
    logic [5:0] third_reg, third_next;
    logic       third_pad_reg, third_pad_next;
    logic [7:0] ch;
    logic [7:0] code;
    logic       is_space;
    logic       ends_comment;

    assign ch           = item.in_char;
    assign code         = map_char(ch);
    assign ends_comment = (ch == CH_NEWLINE) || (ch == CH_FEED);
    assign is_space     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_RETURN)
                          || ends_comment;

    always_comb
    begin
        phase_next     = phase_reg;
        comment_next   = comment_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        third_pad_next = third_pad_reg;
        job_push       = 1'b0;
        job            = '0;
        if (accept && phase_reg != PH_DONE && phase_reg != PH_FAILED) begin
            if (item.end_of_text) begin
                job_push     = 1'b1;
                job.count    = 2'd1;
                job.kind     = KIND_ERROR;
                phase_next   = PH_FAILED;
                comment_next = 1'b0;
            end else if (phase_reg == PH_OPEN) begin
                if (ch != CH_OPEN) begin
                    job_push     = 1'b1;
                    job.count    = 2'd1;
                    job.kind     = KIND_ERROR;
                    job.offender = ch;
                    phase_next   = PH_FAILED;
                end else begin
                    phase_next = PH_G1;
                end
            end else if (comment_reg) begin
                if (ends_comment) begin
                    comment_next = 1'b0;
                end
            end else if (is_space) begin
                comment_next = 1'b0;
            end else if (ch == CH_HASH) begin
                comment_next = 1'b1;
            end else if (ch == CH_CLOSE && phase_reg == PH_G1) begin
                job_push   = 1'b1;
                job.count  = 2'd1;
                job.kind   = KIND_CLOSE;
                phase_next = PH_DONE;
            end else if (code == CODE_BAD
                         || (code == CODE_PAD && (phase_reg == PH_G1 || phase_reg == PH_G2)))
            begin
                job_push     = 1'b1;
                job.count    = 2'd1;
                job.kind     = KIND_ERROR;
                job.offender = ch;
                phase_next   = PH_FAILED;
            end else begin
                unique case (phase_reg)
                    PH_G1:
                    begin
                        first_next = code[5:0];
                        phase_next = PH_G2;
                    end
                    PH_G2:
                    begin
                        second_next = code[5:0];
                        phase_next  = PH_G3;
                    end
                    PH_G3:
                    begin
                        third_pad_next = (code == CODE_PAD);
                        third_next     = (code == CODE_PAD) ? 6'd0 : code[5:0];
                        phase_next     = PH_G4;
                    end
                    default:
                    begin
                        job_push  = 1'b1;
                        job.kind  = KIND_DATA;
                        job.byte0 = {first_reg, second_reg[5:4]};
                        job.byte1 = {second_reg[3:0], third_reg[5:2]};
                        job.byte2 = {third_reg[1:0], code[5:0]};
                        if (third_pad_reg) begin
                            job.count = 2'd1;
                        end else if (code == CODE_PAD) begin
                            job.count = 2'd2;
                        end else begin
                            job.count = 2'd3;
                        end
                        first_next     = 6'd0;
                        second_next    = 6'd0;
                        third_next     = 6'd0;
                        third_pad_next = 1'b0;
                        phase_next     = PH_G1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_OPEN;
            comment_reg   <= 1'b0;
            first_reg     <= 6'd0;
            second_reg    <= 6'd0;
            third_reg     <= 6'd0;
            third_pad_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            comment_reg   <= comment_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            third_reg     <= third_next;
            third_pad_reg <= third_pad_next;
        end
    end

endmodule

// ===== rtl/core/b64bd_fifo.sv =====
// Short job queue between the front end and the result sequencer.
module b64bd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64bd_pkg::job_t  push_job,
    input  logic            pop,
    output b64bd_pkg::job_t  head,
    output logic            fifo_empty,
    output logic            fifo_full
);
    import b64bd_pkg::*;

    job_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign fifo_empty = (count_reg == '0);
    assign fifo_full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/b64bd_back.sv =====
// Back end: expands queued jobs into result words held in an output register.
module b64bd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64bd_pkg::job_t      head,
    input  logic                fifo_empty,
    output logic                fifo_pop,
    input  logic                pop,
    output logic                empty,
    output b64bd_pkg::out_word_t result
);
    import b64bd_pkg::*;

    logic       valid_reg;
    out_word_t  out_reg, out_next;
    logic [1:0] idx_reg;
    logic       load;
    logic       step;
    logic       is_last;

    assign load     = !valid_reg || pop;
    assign step     = load && !fifo_empty;
    assign is_last  = (idx_reg == head.count - 2'd1);
    assign fifo_pop = step && is_last;
    assign empty    = !valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        out_next          = '0;
        out_next.kind     = head.kind;
        out_next.offender = head.offender;
        out_next.last     = is_last;
        case (idx_reg)
            2'd0:    out_next.out_byte = head.byte0;
            2'd1:    out_next.out_byte = head.byte1;
            default: out_next.out_byte = head.byte2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= !fifo_empty;
            end
            if (step) begin
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

endmodule

// ===== tb/tb_base64_blob_decoder.sv =====
// Self-checking testbench for the base64 blob decoder with directed and random text.
module tb_base64_blob_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import b64bd_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int LIMIT_CYCLES = 200000;
    localparam int GROUP_CHARS  = 100;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef enum logic [2:0] {
        PH_WAIT_OPEN,
        PH_G1,
        PH_G2,
        PH_G3,
        PH_G4,
        PH_CLOSED,
        PH_FAILED
    } dec_phase_e;

    typedef enum int {
        END_CLOSE,
        END_EOT,
        END_OPEN_GROUP,
        END_EARLY_PAD,
        END_BAD_CHAR,
        END_NUL
    } end_kind_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       fixed;
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } row_t;

    localparam int N_DIRECTED = 25;
    localparam row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        {CH_OPEN, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        {"A",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"A",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"A",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"A",     1'b0, 1'b1, 2'd3, 8'h00, 8'h00, 8'h00},
        {"/",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"/",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"/",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"/",     1'b0, 1'b1, 2'd3, 8'hFF, 8'hFF, 8'hFF},
        {CH_SP,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_TAB,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_HASH, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_CLOSE,1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_LF,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"Q",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"Q",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_PAD,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"z",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"T",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"W",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_CR,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {"E",     1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_PAD,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_HASH, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        {CH_FF,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_word_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_word_t result;

    dec_phase_e dec_phase;
    logic       in_comment;
    logic [5:0] sextet_a;
    logic [5:0] sextet_b;
    logic [5:0] sextet_c;
    logic       third_pad;

    out_word_t  step_words [0:2];
    int         step_n;

    out_word_t  expected_words [$];
    row_t       text_rows [$];
    int         error_count = 0;
    int         cycle_count = 0;

    base64_blob_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_base64_blob_decoder: done, errors");
            $finish;
        end
    end

    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c - "A";
        else if (c >= "a" && c <= "z")
            return c - "a" + 8'd26;
        else if (c >= "0" && c <= "9")
            return c - "0" + 8'd52;
        else if (c == "+")
            return 8'd62;
        else if (c == "/")
            return 8'd63;
        else if (c == CH_PAD)
            return CODE_PAD;
        return CODE_BAD;
    endfunction

    function automatic logic [7:0] b64_char(input int idx);
        if (idx < 26)
            return 8'("A" + idx);
        else if (idx < 52)
            return 8'("a" + idx - 26);
        else if (idx < 62)
            return 8'("0" + idx - 52);
        else if (idx == 62)
            return "+";
        return "/";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF;
    endfunction

    function automatic void note_word(input logic [7:0] b, input logic [1:0] k,
                                      input logic [7:0] off);
        step_words[step_n].out_byte = b;
        step_words[step_n].kind     = k;
        step_words[step_n].offender = off;
        step_words[step_n].last     = 1'b0;
        step_n++;
    endfunction

    function automatic void fail_on(input logic [7:0] off);
        note_word(8'h00, KIND_ERROR, off);
        dec_phase  = PH_FAILED;
        in_comment = 1'b0;
    endfunction

    function automatic void decode_char(input in_word_t w);
        logic [7:0] c;
        logic [7:0] code;
        c = w.in_char;
        step_n = 0;
        if (dec_phase == PH_CLOSED || dec_phase == PH_FAILED)
            return;
        if (w.end_of_text)
            fail_on(8'h00);
        else if (dec_phase == PH_WAIT_OPEN)
        begin
            if (c != CH_OPEN)
                fail_on(c);
            else
                dec_phase = PH_G1;
        end
        else if (in_comment)
        begin
            if (c == CH_LF || c == CH_FF)
                in_comment = 1'b0;
        end
        else if (is_blank(c))
        begin
        end
        else if (c == CH_HASH)
            in_comment = 1'b1;
        else if (c == CH_CLOSE && dec_phase == PH_G1)
        begin
            note_word(8'h00, KIND_CLOSE, 8'h00);
            dec_phase = PH_CLOSED;
        end
        else
        begin
            code = sextet_of(c);
            if (code == CODE_BAD)
                fail_on(c);
            else
            begin
                case (dec_phase)
                    PH_G1:
                    begin
                        if (code == CODE_PAD)
                            fail_on(c);
                        else
                        begin
                            sextet_a  = code[5:0];
                            dec_phase = PH_G2;
                        end
                    end
                    PH_G2:
                    begin
                        if (code == CODE_PAD)
                            fail_on(c);
                        else
                        begin
                            sextet_b  = code[5:0];
                            dec_phase = PH_G3;
                        end
                    end
                    PH_G3:
                    begin
                        third_pad = (code == CODE_PAD);
                        sextet_c  = (code == CODE_PAD) ? 6'd0 : code[5:0];
                        dec_phase = PH_G4;
                    end
                    default:
                    begin
                        note_word({sextet_a, sextet_b[5:4]}, KIND_DATA, 8'h00);
                        if (!third_pad)
                        begin
                            note_word({sextet_b[3:0], sextet_c[5:2]}, KIND_DATA, 8'h00);
                            if (code != CODE_PAD)
                                note_word({sextet_c[1:0], code[5:0]}, KIND_DATA, 8'h00);
                        end
                        sextet_a  = 6'd0;
                        sextet_b  = 6'd0;
                        sextet_c  = 6'd0;
                        third_pad = 1'b0;
                        dec_phase = PH_G1;
                    end
                endcase
            end
        end
        if (step_n > 0)
            step_words[step_n-1].last = 1'b1;
    endfunction

    function automatic int draw_wait(inout int run_left, inout bit quiet);
        if (run_left == 0)
        begin
            run_left = $urandom_range(4, 30);
            quiet    = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void add_row(input logic [7:0] c, input logic e);
        row_t r;
        r = '0;
        r.ch  = c;
        r.eot = e;
        text_rows.push_back(r);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 4))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_CR;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] comment_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LF || c == CH_FF);
        return c;
    endfunction

    function automatic void build_text();
        int         group_chars;
        int         pick;
        bit         pad3;
        logic [7:0] c;
        end_kind_e  ending;
        group_chars = 0;
        for (int i = 0; i < N_DIRECTED; i++)
            text_rows.push_back(DIRECTED_ROWS[i]);
        while (group_chars < GROUP_CHARS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                pad3 = ($urandom_range(0, 6) == 0);
                for (int k = 0; k < 4; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        add_row(blank_char(), 1'b0);
                    if (k < 2 || (k == 2 && !pad3))
                        c = b64_char($urandom_range(0, 63));
                    else if (k == 2)
                        c = CH_PAD;
                    else if ($urandom_range(0, 5) == 0)
                        c = CH_PAD;
                    else
                        c = b64_char($urandom_range(0, 63));
                    add_row(c, 1'b0);
                    group_chars++;
                end
            end
            else if (pick < 85)
                add_row(blank_char(), 1'b0);
            else
            begin
                add_row(CH_HASH, 1'b0);
                repeat ($urandom_range(1, 6))
                    add_row(comment_byte(), 1'b0);
                add_row($urandom_range(0, 1) ? CH_LF : CH_FF, 1'b0);
            end
        end
        ending = end_kind_e'($urandom_range(0, 5));
        case (ending)
            END_CLOSE:
                add_row(CH_CLOSE, 1'b0);
            END_EOT:
            begin
                if ($urandom_range(0, 1))
                begin
                    add_row(CH_HASH, 1'b0);
                    add_row(comment_byte(), 1'b0);
                end
                add_row(8'($urandom_range(0, 255)), 1'b1);
            end
            END_OPEN_GROUP:
            begin
                repeat ($urandom_range(1, 3))
                    add_row(b64_char($urandom_range(0, 63)), 1'b0);
                add_row(CH_CLOSE, 1'b0);
            end
            END_EARLY_PAD:
            begin
                if ($urandom_range(0, 1))
                    add_row(b64_char($urandom_range(0, 63)), 1'b0);
                add_row(CH_PAD, 1'b0);
            end
            END_BAD_CHAR:
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (sextet_of(c) != CODE_BAD || is_blank(c) || c == CH_HASH
                       || c == CH_CLOSE);
                add_row(c, 1'b0);
            end
            default:
                add_row(8'h00, 1'b0);
        endcase
        repeat (8)
            add_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    initial
    begin
        int         send_left;
        bit         send_quiet;
        int         gap;
        row_t       r;
        in_word_t   w;
        out_word_t  tw;

        send_left  = 0;
        send_quiet = 1'b0;
        dec_phase  = PH_WAIT_OPEN;
        in_comment = 1'b0;
        sextet_a   = 6'd0;
        sextet_b   = 6'd0;
        sextet_c   = 6'd0;
        third_pad  = 1'b0;
        build_text();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (text_rows[i])
        begin
            r = text_rows[i];
            w.in_char     = r.ch;
            w.end_of_text = r.eot;
            gap = draw_wait(send_left, send_quiet);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
            @(negedge clk);
            push <= 1'b1;
            item <= w;
            @(posedge clk);
            while (full)
                @(posedge clk);
            decode_char(w);
            if (r.fixed)
            begin
                for (int k = 0; k < r.n; k++)
                begin
                    tw.out_byte = (k == 0) ? r.b0 : (k == 1) ? r.b1 : r.b2;
                    tw.kind     = KIND_DATA;
                    tw.offender = 8'h00;
                    tw.last     = (k == r.n - 1);
                    expected_words.push_back(tw);
                end
            end
            else
            begin
                for (int k = 0; k < step_n; k++)
                    expected_words.push_back(step_words[k]);
            end
        end
        @(negedge clk);
        push <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_base64_blob_decoder: done, clean");
        else
            $display("tb_base64_blob_decoder: done, errors");
        $finish;
    end

    initial
    begin
        int        take_left;
        bit        take_quiet;
        int        stall;
        out_word_t exp_w;

        take_left  = 0;
        take_quiet = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = draw_wait(take_left, take_quiet);
            repeat (stall)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word: byte %h kind %0d offender %h last %b",
                         $realtime, result.out_byte, result.kind, result.offender,
                         result.last);
                error_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (result.out_byte !== exp_w.out_byte || result.kind !== exp_w.kind
                    || result.offender !== exp_w.offender || result.last !== exp_w.last)
                begin
                    $display("%0t: mismatch: expected %h %0d %h %b, got %h %0d %h %b",
                             $realtime, exp_w.out_byte, exp_w.kind, exp_w.offender,
                             exp_w.last, result.out_byte, result.kind, result.offender,
                             result.last);
                    error_count++;
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/b64bd_pkg.sv
rtl/core/b64bd_front.sv
rtl/core/b64bd_fifo.sv
rtl/core/b64bd_back.sv
rtl/core/base64_blob_decoder.sv
tb/tb_base64_blob_decoder.sv
